// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the date adder blocks. They compile
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define CDAD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("cdad assertion failed");
// Expression must never be true at a clock edge outside reset.
`define CDAD_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("cdad forbidden condition seen");
`else
`define CDAD_ASSERT(lbl, clk, rst_n, prop)
`define CDAD_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== hw/rtl/cdad_pkg.sv =====
// ----------------------------------------------------------------------------
// cdad_pkg
// Types, constants and calendar tables shared by the date adder modules.
// ----------------------------------------------------------------------------
package cdad_pkg;

	localparam int LAST_YEAR_DEF = 4095;
	localparam logic [11:0] BASE_YEAR_RST = 12'd1900;

	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 12;
	localparam int OFF_W  = 21;
	localparam int WDAY_W = 3;
	localparam int DOY_W  = 9;
	localparam int STAT_W = 2;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_BEFORE  = 2'd2,
		ST_PAST    = 2'd3
	} status_t;

	// Year stride sizes walked from coarse to fine.
	typedef enum logic [2:0] {
		PH_2000 = 3'd0,
		PH_400  = 3'd1,
		PH_100  = 3'd2,
		PH_20   = 3'd3,
		PH_4    = 3'd4,
		PH_1    = 3'd5
	} phase_t;

	typedef struct packed {
		logic load;
		logic walk;
		logic inv;
		logic restart;
		logic calc;
		logic ychk;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic walk_done;
		logic fail;
	} sts_t;

	function automatic logic [10:0] stride_years(input phase_t ph);
		logic [10:0] r;
		unique case (ph)
			PH_2000: r = 11'd2000;
			PH_400:  r = 11'd400;
			PH_100:  r = 11'd100;
			PH_20:   r = 11'd20;
			PH_4:    r = 11'd4;
			PH_1:    r = 11'd1;
			default: r = 11'd0;
		endcase
		return r;
	endfunction

	// Days in one stride, less the leap day of the stride's first year.
	function automatic logic [19:0] base_days(input phase_t ph);
		logic [19:0] r;
		unique case (ph)
			PH_2000: r = 20'd730484;
			PH_400:  r = 20'd146096;
			PH_100:  r = 20'd36524;
			PH_20:   r = 20'd7304;
			PH_4:    r = 20'd1460;
			PH_1:    r = 20'd365;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] base_mod7(input phase_t ph);
		logic [2:0] r;
		unique case (ph)
			PH_2000: r = 3'd6;
			PH_400:  r = 3'd6;
			PH_100:  r = 3'd5;
			PH_20:   r = 3'd3;
			PH_4:    r = 3'd4;
			PH_1:    r = 3'd1;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// Leap flag of the cursor year after one stride of this size.
	function automatic logic leap_after(input phase_t ph);
		logic r;
		unique case (ph)
			PH_2000, PH_400, PH_20, PH_4: r = 1'b1;
			PH_100, PH_1:                 r = 1'b0;
			default:                      r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic phase_t next_phase(input phase_t ph);
		phase_t r;
		unique case (ph)
			PH_2000: r = PH_400;
			PH_400:  r = PH_100;
			PH_100:  r = PH_20;
			PH_20:   r = PH_4;
			PH_4:    r = PH_1;
			PH_1:    r = PH_1;
			default: r = PH_1;
		endcase
		return r;
	endfunction

	// Days in the months before month m.
	function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		if (leap && m > 4'd2 && m < 4'd13) begin
			r = r + 9'd1;
		end
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			4'd2:                             r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:          r = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			default:                          r = 5'd0;
		endcase
		return r;
	endfunction

	// Remainder by seven: octal digits are summed since eight is one mod seven.
	function automatic logic [2:0] mod7_12(input logic [11:0] x);
		logic [4:0] s1;
		logic [3:0] s2;
		s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[11:9]);
		s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
		return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : 3'(s2);
	endfunction

endpackage

// ===== hw/rtl/calendar_date_add_days_unit.sv =====
// ----------------------------------------------------------------------------
// calendar_date_add_days_unit
// Adds a signed day offset to a Gregorian date and returns the new date with
// its weekday, day of year and a status code.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents (lowest bits first)
//   s_axis    in         day, month, year, offset
//   m_axis    out        new_day, new_month, new_year, weekday, day_of_year;
//                        status in tuser
//   cfg       in         base_year, written whenever cfg_we is high
//
// The year walk sets how long an item takes from one accepted beat to the next:
// a cursor steps strides of 2000, 400, 100, 20, 4 and 1 years, one stride or
// one change of stride size per cycle, up to the input year and, for a date
// that passes the checks, again up to the year of the summed count.
// Reset clears the sequencer and output valid and sets base_year to 1900.
// A waiting result lets the next beat in; the one after holds until it is taken.
//
// Status codes: 0 good, 1 input date rejected, 2 result before base_year,
// 3 result after the last supported year. On a nonzero status all date
// fields of the result are zero.
// ----------------------------------------------------------------------------
module calendar_date_add_days_unit #(
	parameter int LAST_YEAR = cdad_pkg::LAST_YEAR_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// Configuration write.
	input  logic                              cfg_we,
	input  logic [cdad_pkg::YEAR_W-1:0]       cfg_wdata,

	// Input date stream.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// day[4:0], month[8:5], year[20:9], offset[41:21], zero pad[47:42]
	input  logic [cdad_pkg::IN_TDATA_W-1:0]   s_axis_tdata,

	// Result stream.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// new_day[4:0], new_month[8:5], new_year[20:9], weekday[23:21],
	// day_of_year[32:24], zero pad[39:33]
	output logic [cdad_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// status[1:0]
	output logic [cdad_pkg::STAT_W-1:0]       m_axis_tuser
);

	cdad_pkg::cmd_t cmd;
	cdad_pkg::sts_t sts;

	// The controller owns the handshakes and the order of the phases; the
	// datapath owns every calendar value and reports when a walk is finished
	// and whether the item has already failed.
	cdad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	cdad_dp #(
		.LAST_YEAR (LAST_YEAR)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

// ===== hw/rtl/cdad_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdad_ctrl
// Sequencer of the date adder: input handshake, walk phases, result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdad_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output cdad_pkg::cmd_t   cmd,
	input  cdad_pkg::sts_t   sts
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_FWD  = 7'b0000010,
		S_CHK  = 7'b0000100,
		S_SEL  = 7'b0001000,
		S_INV  = 7'b0010000,
		S_YCHK = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_FWD;
				end
			end
			S_FWD: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				cmd.calc = 1'b1;
				state_d  = S_SEL;
			end
			S_SEL: begin
				if (sts.fail) begin
					state_d = S_DONE;
				end else begin
					cmd.restart = 1'b1;
					state_d     = S_INV;
				end
			end
			S_INV: begin
				cmd.walk = 1'b1;
				cmd.inv  = 1'b1;
				if (sts.walk_done) begin
					state_d = S_YCHK;
				end
			end
			S_YCHK: begin
				cmd.ychk = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// A finished result never replaces one that is still waiting.
	`CDAD_NEVER(a_no_overwrite, clk, arst_n, cmd.out_load && out_valid_q && !out_ready)
	// An accepted beat keeps the input side closed on the next cycle.
	`CDAD_ASSERT(a_accept_busy, clk, arst_n, in_valid && in_ready |=> !in_ready)
	// A rejected date or an early count skips the inverse walk.
	`CDAD_ASSERT(a_fail_skip, clk, arst_n, (state_q == S_SEL) && sts.fail |=> state_q == S_DONE)
	// The inverse walk only runs on an item still marked good.
	`CDAD_ASSERT(a_inv_ok, clk, arst_n, (state_q == S_INV) |-> !sts.fail)

endmodule

// ===== hw/rtl/cdad_dp.sv =====
// ----------------------------------------------------------------------------
// cdad_dp
// Datapath of the date adder: year walk cursor, day count, result fields.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdad_dp #(
	parameter int LAST_YEAR = cdad_pkg::LAST_YEAR_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cdad_pkg::YEAR_W-1:0]         cfg_wdata,
	input  logic [cdad_pkg::IN_TDATA_W-1:0]     in_data,
	input  cdad_pkg::cmd_t                      cmd,
	output cdad_pkg::sts_t                      sts,
	output logic [cdad_pkg::OUT_TDATA_W-1:0]    out_data,
	output logic [cdad_pkg::STAT_W-1:0]         out_user
);

	// Cursor years and day counts must hold the latest reachable year plus
	// one coarse stride of look-ahead.
	localparam int YW = $clog2(LAST_YEAR + 5000);
	localparam int DU = $clog2(366 * (LAST_YEAR + 5000));
	localparam int DW = DU + 1;

	localparam int DAY_W  = cdad_pkg::DAY_W;
	localparam int MON_W  = cdad_pkg::MON_W;
	localparam int YEAR_W = cdad_pkg::YEAR_W;
	localparam int OFF_W  = cdad_pkg::OFF_W;
	localparam int DOY_W  = cdad_pkg::DOY_W;
	localparam int WDAY_W = cdad_pkg::WDAY_W;
	localparam int PAD_W  = cdad_pkg::OUT_TDATA_W - (DAY_W + MON_W + YEAR_W + WDAY_W + DOY_W);

	logic [YEAR_W-1:0]    base_q;
	cdad_pkg::phase_t     ph_q;
	cdad_pkg::status_t    status_q;

	logic [DAY_W-1:0]     day_q;
	logic [MON_W-1:0]     mon_q;
	logic [YEAR_W-1:0]    yr_q;
	logic [OFF_W-1:0]     off_q;
	logic [YW-1:0]        cur_y_q;
	logic [DU-1:0]        cur_d_q;
	logic [2:0]           cur_w_q;
	logic                 leap_q;
	logic [DW-1:0]        a_q;
	logic [DOY_W-1:0]     rem0_q;

	logic [DAY_W-1:0]     o_day_q;
	logic [MON_W-1:0]     o_mon_q;
	logic [YEAR_W-1:0]    o_yr_q;
	logic [WDAY_W-1:0]    o_wd_q;
	logic [DOY_W-1:0]     o_doy_q;
	logic [cdad_pkg::STAT_W-1:0] o_st_q;

	logic [YW-1:0]        tgt_y;
	logic [YW-1:0]        cand_y;
	logic [DU-1:0]        cand_d;
	logic [3:0]           w_sum;
	logic [2:0]           w_next;
	logic                 take;
	logic                 invalid;
	logic [8:0]           in_yday;
	logic [DW-1:0]        a_sum;
	logic [DU-1:0]        rem_full;
	logic [MON_W-1:0]     mon_n;
	logic [DAY_W-1:0]     day_n;
	logic [DOY_W-1:0]     doy_n;
	logic [WDAY_W-1:0]    wd_n;

	// One stride of the year cursor.
	assign tgt_y  = YW'(yr_q);
	assign cand_y = cur_y_q + YW'(cdad_pkg::stride_years(ph_q));
	assign cand_d = cur_d_q + DU'(cdad_pkg::base_days(ph_q)) + DU'(leap_q);
	assign w_sum  = 4'(cur_w_q) + 4'(cdad_pkg::base_mod7(ph_q)) + 4'(leap_q);
	assign w_next = (w_sum >= 4'd7) ? 3'(w_sum - 4'd7) : 3'(w_sum);
	assign take   = cmd.inv ? (cand_d <= a_q[DU-1:0]) : (cand_y <= tgt_y);

	assign sts.walk_done = cmd.walk && !take && (ph_q == cdad_pkg::PH_1);
	assign sts.fail      = (status_q != cdad_pkg::ST_OK);

	// Input date check, done once the cursor sits on the input year.
	assign invalid = (tgt_y < YW'(base_q)) || (tgt_y > YW'(LAST_YEAR))
		|| (mon_q == 4'd0) || (mon_q > 4'd12) || (day_q == 5'd0)
		|| (day_q > cdad_pkg::month_len(mon_q, leap_q));

	assign in_yday = cdad_pkg::cum_days(mon_q, leap_q) + 9'(day_q) - 9'd1;
	assign a_sum = {1'b0, cur_d_q} + DW'(in_yday) + {{(DW-OFF_W){off_q[OFF_W-1]}}, off_q};

	assign rem_full = a_q[DU-1:0] - cur_d_q;

	// Month scan over the day of year, then weekday from the running count.
	always_comb begin
		mon_n = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (cdad_pkg::cum_days(4'(k), leap_q) <= rem0_q) begin
				mon_n = 4'(k);
			end
		end
	end

	assign day_n = 5'(rem0_q - cdad_pkg::cum_days(mon_n, leap_q) + 9'd1);
	assign doy_n = rem0_q + 9'd1;
	assign wd_n  = cdad_pkg::mod7_12(12'(cur_w_q) + 12'(rem0_q) + 12'd6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= cdad_pkg::BASE_YEAR_RST;
			ph_q     <= cdad_pkg::PH_2000;
			status_q <= cdad_pkg::ST_OK;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (cmd.load || cmd.restart) begin
				ph_q <= cdad_pkg::PH_2000;
			end else if (cmd.walk && !take) begin
				ph_q <= cdad_pkg::next_phase(ph_q);
			end
			if (cmd.calc) begin
				if (invalid) begin
					status_q <= cdad_pkg::ST_INVALID;
				end else if (a_sum[DW-1]) begin
					status_q <= cdad_pkg::ST_BEFORE;
				end else begin
					status_q <= cdad_pkg::ST_OK;
				end
			end else if (cmd.ychk) begin
				if (cur_y_q < YW'(base_q)) begin
					status_q <= cdad_pkg::ST_BEFORE;
				end else if (cur_y_q > YW'(LAST_YEAR)) begin
					status_q <= cdad_pkg::ST_PAST;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_q <= in_data[4:0];
			mon_q <= in_data[8:5];
			yr_q  <= in_data[20:9];
			off_q <= in_data[41:21];
		end
		if (cmd.load || cmd.restart) begin
			cur_y_q <= '0;
			cur_d_q <= '0;
			cur_w_q <= '0;
			leap_q  <= 1'b1;
		end else if (cmd.walk && take) begin
			cur_y_q <= cand_y;
			cur_d_q <= cand_d;
			cur_w_q <= w_next;
			leap_q  <= cdad_pkg::leap_after(ph_q);
		end
		if (cmd.calc) begin
			a_q <= a_sum;
		end
		if (cmd.ychk) begin
			rem0_q <= rem_full[DOY_W-1:0];
		end
		if (cmd.out_load) begin
			o_st_q <= status_q;
			if (status_q == cdad_pkg::ST_OK) begin
				o_day_q <= day_n;
				o_mon_q <= mon_n;
				o_yr_q  <= cur_y_q[YEAR_W-1:0];
				o_wd_q  <= wd_n;
				o_doy_q <= doy_n;
			end else begin
				o_day_q <= '0;
				o_mon_q <= '0;
				o_yr_q  <= '0;
				o_wd_q  <= '0;
				o_doy_q <= '0;
			end
		end
	end

	assign out_data = {{PAD_W{1'b0}}, o_doy_q, o_wd_q, o_yr_q, o_mon_q, o_day_q};
	assign out_user = o_st_q;

	// The forward walk never passes the input year.
	`CDAD_ASSERT(a_fwd_bound, clk, arst_n, cmd.walk && !cmd.inv |-> cur_y_q <= tgt_y)
	// The inverse walk never passes the target day count.
	`CDAD_ASSERT(a_inv_bound, clk, arst_n, cmd.walk && cmd.inv |-> cur_d_q <= a_q[DU-1:0])
	// The inverse walk starts only from a nonnegative count.
	`CDAD_NEVER(a_inv_sign, clk, arst_n, cmd.walk && cmd.inv && a_q[DW-1])
	// A good result lands inside one year.
	`CDAD_ASSERT(a_rem_range, clk, arst_n, cmd.out_load && !sts.fail |-> rem0_q <= 9'd365)

endmodule

// ===== verif/calendar_date_add_days_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_days_unit_tb
// Self-checking bench for the date adder. Requests come from a queue through a
// randomly idling driver, each accepted request is predicted in the bench and
// every result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module calendar_date_add_days_unit_tb;

	localparam int LAST_YEAR       = cdad_pkg::LAST_YEAR_DEF;
	localparam int RANDOM_PER_BASE = 120;
	localparam int STALL_LIMIT     = 4000;
	localparam int TAIL_CYCLES     = 100;
	localparam int OFF_MIN         = -1048576;
	localparam int OFF_MAX         = 1048575;

	// One request beat as the bench sees it.
	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic [20:0] offset;
	} date_req_t;

	// One result beat, status carried beside the date fields.
	typedef struct packed {
		logic [4:0] day;
		logic [3:0] month;
		logic [11:0] year;
		logic [2:0] weekday;
		logic [8:0] yday;
		cdad_pkg::status_t status;
	} date_res_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [cdad_pkg::YEAR_W-1:0]      cfg_wdata = '0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	// day, month, year, offset, zero pad
	logic [cdad_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	// new_day, new_month, new_year, weekday, day_of_year, zero pad
	logic [cdad_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	// status
	logic [cdad_pkg::STAT_W-1:0]      m_axis_tuser;

	// Month keys of the table weekday method, January first.
	int month_key [0:11] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

	date_req_t pending_dates[$];   // requests not yet put on the bus
	date_res_t expected_dates[$];  // predictions of results still to come
	date_req_t active_req;         // request currently on the bus
	int        model_base;         // base year the prediction runs with
	int        mismatches = 0;
	int        quiet_cycles = 0;

	// Handshake bookkeeping: set at the rising edge, read at the falling one.
	logic      req_taken = 1'b0;
	logic      res_taken = 1'b0;
	int        src_wait = -1;
	int        snk_wait = -1;
	bit        src_flat = 1'b0;
	bit        snk_flat = 1'b0;
	bit        src_gated = 1'b0;
	bit        snk_gated = 1'b0;

	calendar_date_add_days_unit #(
		.LAST_YEAR(LAST_YEAR)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #1 clk = ~clk;

	// Gregorian leap rule; year zero counts as a leap year.
	function automatic bit leap_year(longint y);
		return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
	endfunction

	function automatic int month_days(longint y, int m);
		case (m)
			2: begin
				return leap_year(y) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				return 30;
			end
			default: begin
				return 31;
			end
		endcase
	endfunction

	// Days from January first of year zero to January first of year y.
	function automatic longint days_to_year(longint y);
		return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	// Ordinal of a date counted from January first of the base year, which is 1.
	function automatic longint day_number(int y, int m, int d, int base);
		longint n;
		n = days_to_year(y) - days_to_year(base) + d;
		for (int i = 1; i < m; i++) begin
			n += month_days(y, i);
		end
		return n;
	endfunction

	// Expected result of adding the request's offset to its date.
	function automatic date_res_t shift_date(date_req_t rq, int base);
		longint total, a, ny, yy;
		int rem, mon;
		date_res_t r;
		r = '0;
		r.status = cdad_pkg::ST_OK;
		if (int'(rq.year) < base || int'(rq.year) > LAST_YEAR || rq.month < 4'd1 ||
				rq.month > 4'd12 || rq.day < 5'd1 ||
				int'(rq.day) > month_days(rq.year, int'(rq.month))) begin
			r.status = cdad_pkg::ST_INVALID;
		end else begin
			total = day_number(rq.year, rq.month, rq.day, base) +
				longint'($signed(rq.offset));
			if (total < 1) begin
				r.status = cdad_pkg::ST_BEFORE;
			end else begin
				// Absolute day index, then a year estimate corrected both ways.
				a = days_to_year(base) + total - 1;
				ny = (a * 400) / 146097;
				while (days_to_year(ny + 1) <= a) begin
					ny++;
				end
				while (ny > 0 && days_to_year(ny) > a) begin
					ny--;
				end
				if (ny > LAST_YEAR) begin
					r.status = cdad_pkg::ST_PAST;
				end else begin
					rem = int'(a - days_to_year(ny)) + 1;
					r.yday = 9'(rem);
					mon = 1;
					while (mon < 12 && rem > month_days(ny, mon)) begin
						rem -= month_days(ny, mon);
						mon++;
					end
					r.year = 12'(ny);
					r.month = 4'(mon);
					r.day = 5'(rem);
					// January and February belong to the previous year here; the
					// year is moved up by 400 so no term goes negative.
					yy = ny + 400 - (mon < 3 ? 1 : 0);
					r.weekday = 3'((yy + yy / 4 - yy / 100 + yy / 400 +
						month_key[mon - 1] + rem) % 7);
				end
			end
		end
		return r;
	endfunction

	task automatic push_date(int d, int m, int y, int off);
		date_req_t rq;
		rq.day = 5'(d);
		rq.month = 4'(m);
		rq.year = 12'(y);
		rq.offset = 21'(off);
		pending_dates.push_back(rq);
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Waits until no request is queued or on the bus and no result is
	// outstanding, then returns at a falling edge ready to drive inputs.
	task automatic drain();
		while (pending_dates.size() != 0 || s_axis_tvalid || expected_dates.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Request driver. Before each beat it idles for a drawn number of cycles;
	// for some beats those cycles only count while the block is ready, so the
	// gaps land both inside and after its work on the previous beat.
	always @(negedge clk) begin : request_driver
		if (arst_n && (!s_axis_tvalid || req_taken)) begin
			if (src_wait < 0) begin
				if ($urandom_range(0, 39) == 0) begin
					src_flat = !src_flat;
				end
				src_wait = src_flat ? 0 : int'($urandom_range(0, 19));
				src_gated = $urandom_range(0, 1) == 1;
			end
			if (src_wait == 0 && pending_dates.size() != 0) begin
				active_req = pending_dates.pop_front();
				s_axis_tdata <= {6'd0, active_req.offset, active_req.year,
					active_req.month, active_req.day};
				s_axis_tvalid <= 1'b1;
				src_wait = -1;
			end else begin
				if (src_wait > 0 && (!src_gated || s_axis_tready)) begin
					src_wait--;
				end
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Every accepted request is predicted right away; the base year cannot
	// change while any request is in flight.
	always @(posedge clk) begin : request_accept
		if (s_axis_tvalid && s_axis_tready) begin
			expected_dates.push_back(shift_date(active_req, model_base));
			req_taken <= 1'b1;
		end else begin
			req_taken <= 1'b0;
		end
	end

	// Result sink. After each taken beat it draws a stall; for some beats the
	// stall only counts while a result is actually waiting.
	always @(negedge clk) begin : result_sink
		if (res_taken || snk_wait < 0) begin
			if ($urandom_range(0, 39) == 0) begin
				snk_flat = !snk_flat;
			end
			snk_wait = snk_flat ? 0 : int'($urandom_range(0, 19));
			snk_gated = $urandom_range(0, 1) == 1;
		end
		if (snk_wait > 0) begin
			if (!snk_gated || m_axis_tvalid) begin
				snk_wait--;
			end
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		date_res_t want, got;
		if (m_axis_tvalid && m_axis_tready) begin
			res_taken <= 1'b1;
			got.day = m_axis_tdata[4:0];
			got.month = m_axis_tdata[8:5];
			got.year = m_axis_tdata[20:9];
			got.weekday = m_axis_tdata[23:21];
			got.yday = m_axis_tdata[32:24];
			got.status = cdad_pkg::status_t'(m_axis_tuser);
			if (expected_dates.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %0d/%0d/%0d status %0d",
					$time, got.day, got.month, got.year, got.status);
				mismatches++;
			end else begin
				want = expected_dates.pop_front();
				check_field("new_day", want.day, got.day);
				check_field("new_month", want.month, got.month);
				check_field("new_year", want.year, got.year);
				check_field("weekday", want.weekday, got.weekday);
				check_field("day_of_year", want.yday, got.yday);
				check_field("status", int'(want.status), int'(got.status));
			end
		end else begin
			res_taken <= 1'b0;
		end
	end

	// Ends the run if no beat moves on either side for too long.
	always @(posedge clk) begin : watchdog
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	initial begin : stimulus
		int bases [0:6];
		int base, kind, mlen, y, m, d, jig;
		longint cnt, off;
		bases = '{int'(cdad_pkg::BASE_YEAR_RST), 0, LAST_YEAR, 1, 2024,
			int'($urandom_range(0, 2100)), int'($urandom_range(0, LAST_YEAR))};
		model_base = int'(cdad_pkg::BASE_YEAR_RST);
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 7; p++) begin
			base = bases[p];
			// The first setting is the reset value; later ones are written once
			// the block has gone idle.
			if (p != 0) begin
				drain();
				cfg_wdata <= 12'(base);
				cfg_we <= 1'b1;
				model_base = base;
				@(negedge clk);
				cfg_we <= 1'b0;
			end

			if (p == 0) begin
				push_date(1, 1, 1900, 0);            // first day of the base year
				push_date(1, 1, 1900, -1);           // one day before the base
				push_date(31, 12, LAST_YEAR, 0);     // last supported day
				push_date(31, 12, LAST_YEAR, 1);     // one day past it
				push_date(29, 2, 2000, 0);           // leap by the 400-year rule
				push_date(29, 2, 1900, 0);           // not leap by the 100-year rule
				push_date(29, 2, 2024, 365);
				push_date(28, 2, 2100, 1);           // century year, no leap day
				push_date(31, 12, 1999, 1);
				push_date(31, 1, 2000, 29);
				push_date(0, 1, 2000, 0);            // day zero
				push_date(31, 4, 2000, 0);           // past month end
				push_date(1, 0, 2000, 0);            // month zero
				push_date(1, 13, 2000, 0);
				push_date(31, 15, LAST_YEAR, 0);
				push_date(1, 1, 1899, 0);            // year below base
				push_date(1, 1, 2000, OFF_MAX);
				push_date(15, 6, 3000, OFF_MIN);
				push_date(31, 12, 2000, 366 + 365);
			end else if (base == 0) begin
				push_date(1, 1, 0, 0);               // year zero is leap
				push_date(29, 2, 0, 0);
				push_date(1, 1, 0, OFF_MAX);
				push_date(31, 12, LAST_YEAR, OFF_MIN);
				push_date(1, 3, 0, -60);
			end

			repeat (RANDOM_PER_BASE) begin
				kind = $urandom_range(0, 99);
				// Most requests are valid dates, clustered at both ends of the
				// allowed year range as well as spread across it.
				case ($urandom_range(0, 3))
					0: begin
						y = base + int'($urandom_range(0, 3));
					end
					1: begin
						y = LAST_YEAR - int'($urandom_range(0, 3));
					end
					default: begin
						y = $urandom_range(base, LAST_YEAR);
					end
				endcase
				if (y < base) begin
					y = base;
				end
				if (y > LAST_YEAR) begin
					y = LAST_YEAR;
				end
				m = $urandom_range(1, 12);
				mlen = month_days(y, m);
				d = ($urandom_range(0, 3) == 0) ? mlen : int'($urandom_range(1, mlen));
				cnt = day_number(y, m, d, base);
				jig = int'($urandom_range(0, 2)) - 1;
				// Offsets from small steps to the full range, plus ones aimed at
				// the first day of the base year and the last supported day.
				case ($urandom_range(0, 5))
					0: begin
						off = longint'($urandom_range(0, 800)) - 400;
					end
					1: begin
						off = longint'($urandom_range(0, 80000)) - 40000;
					end
					2: begin
						off = longint'($urandom_range(0, 2097151)) + OFF_MIN;
					end
					3: begin
						off = 1 - cnt + jig;
					end
					4: begin
						off = days_to_year(LAST_YEAR + 1) - days_to_year(base) - cnt + jig;
					end
					default: begin
						off = longint'($urandom_range(0, 1460)) - 730;
					end
				endcase
				if (off < OFF_MIN || off > OFF_MAX) begin
					off = jig;
				end

				if (kind < 15) begin
					// Raw noise over every bit of every field.
					push_date($urandom, $urandom, $urandom, $urandom);
				end else begin
					if (kind < 30) begin
						// Dates that just miss being valid.
						case ($urandom_range(0, 4))
							0: begin
								d = 0;
							end
							1: begin
								d = mlen + 1;
							end
							2: begin
								m = 0;
							end
							3: begin
								m = $urandom_range(13, 15);
							end
							default: begin
								if (base > 0) begin
									y = base - 1;
								end else begin
									m = 13;
								end
							end
						endcase
					end
					push_date(d, m, y, int'(off));
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
